FILE: hdl/ccc_pkg.sv
// ccc_pkg: shared widths and types for the circle contact pipeline.
// Used by the interfaces, the pipeline cells and the top level.
`default_nettype none
package ccc_pkg;
  localparam int CoordW  = 24;
  localparam int RadW    = 20;
  localparam int NormW   = 16;
  localparam int PenW    = 21;
  localparam int DiffW   = 25;          // centre difference
  localparam int SqW     = 50;          // dx*dx + dy*dy
  localparam int RootW   = 25;          // floor(sqrt(S))
  localparam int RootSteps = 25;        // one result bit per cell
  localparam int QuotW   = 15;          // |normal| magnitude, up to 2^14
  localparam int NumW    = 40;          // |d|*2^14 + len/2, divider remainder

  // Input item.
  typedef struct packed {
    logic signed [CoordW-1:0] centre_a_x;
    logic signed [CoordW-1:0] centre_a_y;
    logic signed [CoordW-1:0] centre_b_x;
    logic signed [CoordW-1:0] centre_b_y;
    logic        [RadW-1:0]   radius_a;
    logic        [RadW-1:0]   radius_b;
  } pair_t;

  // Result item.
  typedef struct packed {
    logic                      hit;
    logic signed [NormW-1:0]   normal_x;
    logic signed [NormW-1:0]   normal_y;
    logic        [PenW-1:0]    penetration;
    logic signed [CoordW-1:0]  contact_x;
    logic signed [CoordW-1:0]  contact_y;
  } contact_t;
endpackage
`default_nettype wire

FILE: hdl/ccc_in_if.sv
// ccc_in_if: valid/ready channel carrying one circle pair per item.
// Depends on ccc_pkg.
`default_nettype none
interface ccc_in_if;
  import ccc_pkg::*;
  logic  valid;
  logic  ready;
  pair_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/ccc_out_if.sv
// ccc_out_if: valid/ready channel carrying one contact result per item.
// Depends on ccc_pkg.
`default_nettype none
interface ccc_out_if;
  import ccc_pkg::*;
  logic     valid;
  logic     ready;
  contact_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/ccc_sqrt_cell.sv
// ccc_sqrt_cell: one restoring square-root step, producing one root bit.
// Depends on ccc_pkg; chained by the top level.
`default_nettype none
module ccc_sqrt_cell #(
  parameter int Step = 0
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [ccc_pkg::SqW-1:0]   rem_in,
  input  wire logic [ccc_pkg::RootW-1:0] root_in,
  output logic      [ccc_pkg::SqW-1:0]   rem_out,
  output logic      [ccc_pkg::RootW-1:0] root_out
);
  import ccc_pkg::*;
  localparam int Bit = RootW - 1 - Step;

  logic [SqW+1:0] trial;
  logic [SqW+1:0] rem_ext;

  // Try setting this root bit: compare (2*root + 2^bit) << bit with remainder.
  always_comb begin
    trial   = (({27'd0, root_in} << 1) | ({{(SqW+1){1'b0}}, 1'b1} << Bit)) << Bit;
    rem_ext = {2'b00, rem_in};
  end

  // Advance the remainder and root to the next cell.
  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_ext >= trial) begin
        rem_out  <= rem_in - trial[SqW-1:0];
        root_out <= root_in | (RootW'(1) << Bit);
      end else begin
        rem_out  <= rem_in;
        root_out <= root_in;
      end
    end
  end
endmodule
`default_nettype wire

FILE: hdl/ccc_div_cell.sv
// ccc_div_cell: one restoring division step for both normal components.
// Depends on ccc_pkg; chained by the top level.
`default_nettype none
module ccc_div_cell #(
  parameter int Step = 0
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [ccc_pkg::RootW-1:0] divisor,
  input  wire logic [ccc_pkg::NumW-1:0]  rx_in,
  input  wire logic [ccc_pkg::NumW-1:0]  ry_in,
  input  wire logic [ccc_pkg::QuotW-1:0] qx_in,
  input  wire logic [ccc_pkg::QuotW-1:0] qy_in,
  output logic      [ccc_pkg::NumW-1:0]  rx_out,
  output logic      [ccc_pkg::NumW-1:0]  ry_out,
  output logic      [ccc_pkg::QuotW-1:0] qx_out,
  output logic      [ccc_pkg::QuotW-1:0] qy_out
);
  import ccc_pkg::*;
  localparam int Bit = QuotW - 1 - Step;

  logic [NumW-1:0] dshift;
  logic            ok_x, ok_y;

  // Compare remainders with divisor << bit; a zero divisor gives a zero quotient.
  always_comb begin
    dshift = NumW'(divisor) << Bit;
    ok_x   = (divisor != '0) && (rx_in >= dshift);
    ok_y   = (divisor != '0) && (ry_in >= dshift);
  end

  // Advance partial remainders and quotients.
  always_ff @(posedge clk) begin
    if (en) begin
      rx_out <= ok_x ? rx_in - dshift : rx_in;
      ry_out <= ok_y ? ry_in - dshift : ry_in;
      qx_out <= ok_x ? (qx_in | (QuotW'(1) << Bit)) : qx_in;
      qy_out <= ok_y ? (qy_in | (QuotW'(1) << Bit)) : qy_in;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/circle_circle_contact.sv
// circle_circle_contact: top level of the circle pair contact pipeline.
// Depends on ccc_pkg, ccc_in_if, ccc_out_if, ccc_sqrt_cell, ccc_div_cell.
`default_nettype none
// Accepts one circle pair per cycle and returns one contact result per pair,
// in order. The stages are two for differences and squares, 25 square
// root cells (one root bit each), one for overlap and dividend, 15 division
// cells (one normal bit each), one for signing the normal, one for the
// contact products and one output register. The whole pipeline advances when
// the output register is empty or being taken, so ready is low only while the
// output stalls or during reset.
module circle_circle_contact (
  input wire logic clk,
  input wire logic rst,
  ccc_in_if.sink   pair_in,
  ccc_out_if.source contact_out
);
  import ccc_pkg::*;
  localparam int Depth = 45;
  localparam int NF = 14;
  localparam int CF = 8;
  localparam int OvW = 26;

  logic en;
  logic [Depth-1:0] vld;
  assign en = !contact_out.valid || contact_out.ready;
  assign pair_in.ready = en && !rst;

  // Hold the valid bits of every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], pair_in.valid};
    end
  end

  // Stage 1: differences.
  logic signed [DiffW-1:0] s1_dx, s1_dy;
  pair_t s1_p;
  always_ff @(posedge clk) begin
    if (en) begin
      s1_p  <= pair_in.data;
      s1_dx <= DiffW'(pair_in.data.centre_b_x) - DiffW'(pair_in.data.centre_a_x);
      s1_dy <= DiffW'(pair_in.data.centre_b_y) - DiffW'(pair_in.data.centre_a_y);
    end
  end

  // Stage 2: squared distance.
  logic signed [DiffW-1:0] s2_dx, s2_dy;
  pair_t s2_p;
  logic [SqW-1:0] s2_sq;
  logic signed [2*DiffW-1:0] sqx, sqy;
  assign sqx = s1_dx * s1_dx;
  assign sqy = s1_dy * s1_dy;
  always_ff @(posedge clk) begin
    if (en) begin
      s2_p  <= s1_p;
      s2_dx <= s1_dx;
      s2_dy <= s1_dy;
      s2_sq <= SqW'(sqx) + SqW'(sqy);
    end
  end

  // Square root cells, with side data carried alongside.
  logic [SqW-1:0]   rem  [RootSteps+1];
  logic [RootW-1:0] root [RootSteps+1];
  pair_t sp [RootSteps+1];
  logic signed [DiffW-1:0] sdx [RootSteps+1];
  logic signed [DiffW-1:0] sdy [RootSteps+1];
  assign rem[0]  = s2_sq;
  assign root[0] = '0;
  assign sp[0]   = s2_p;
  assign sdx[0]  = s2_dx;
  assign sdy[0]  = s2_dy;
  for (genvar i = 0; i < RootSteps; i++) begin : g_sqrt
    ccc_sqrt_cell #(.Step(i)) u_cell (
      .clk(clk), .en(en), .rem_in(rem[i]), .root_in(root[i]),
      .rem_out(rem[i+1]), .root_out(root[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        sp[i+1]  <= sp[i];
        sdx[i+1] <= sdx[i];
        sdy[i+1] <= sdy[i];
      end
    end
  end

  // Overlap and rounding-biased dividends.
  logic signed [OvW-1:0] ov_c;
  logic [RootW-1:0] len3;
  logic signed [OvW-1:0] ov3;
  logic sx3, sy3;
  logic [DiffW-1:0] mx, my;
  pair_t p3;
  always_comb begin
    ov_c = OvW'(sp[RootSteps].radius_a) + OvW'(sp[RootSteps].radius_b) - OvW'(1 << CF)
         - OvW'({root[RootSteps] >> CF, {CF{1'b0}}});
    mx = sdx[RootSteps][DiffW-1] ? -sdx[RootSteps] : sdx[RootSteps];
    my = sdy[RootSteps][DiffW-1] ? -sdy[RootSteps] : sdy[RootSteps];
  end
  // The division needs (m*2^14 + len/2)/len; m <= len so quotient <= 2^14.
  logic [NumW-1:0] nx3, ny3;
  always_ff @(posedge clk) begin
    if (en) begin
      p3   <= sp[RootSteps];
      len3 <= root[RootSteps];
      ov3  <= ov_c;
      sx3  <= sdx[RootSteps][DiffW-1];
      sy3  <= sdy[RootSteps][DiffW-1];
      nx3  <= (NumW'(mx) << NF) + NumW'(root[RootSteps] >> 1);
      ny3  <= (NumW'(my) << NF) + NumW'(root[RootSteps] >> 1);
    end
  end

  // Division cells: one quotient bit per cell, side data carried alongside.
  logic [NumW-1:0]  nrx [QuotW+1];
  logic [NumW-1:0]  nry [QuotW+1];
  logic [QuotW-1:0] qx [QuotW+1];
  logic [QuotW-1:0] qy [QuotW+1];
  pair_t dp [QuotW+1];
  logic [RootW-1:0] dl [QuotW+1];
  logic signed [OvW-1:0] dov [QuotW+1];
  logic dsx [QuotW+1];
  logic dsy [QuotW+1];
  assign nrx[0] = nx3;
  assign nry[0] = ny3;
  assign qx[0] = '0;
  assign qy[0] = '0;
  assign dp[0] = p3;
  assign dl[0] = len3;
  assign dov[0] = ov3;
  assign dsx[0] = sx3;
  assign dsy[0] = sy3;
  for (genvar j = 0; j < QuotW; j++) begin : g_div
    ccc_div_cell #(.Step(j)) u_cell (
      .clk(clk), .en(en), .divisor(dl[j]), .rx_in(nrx[j]), .ry_in(nry[j]),
      .qx_in(qx[j]), .qy_in(qy[j]), .rx_out(nrx[j+1]), .ry_out(nry[j+1]),
      .qx_out(qx[j+1]), .qy_out(qy[j+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        dp[j+1]  <= dp[j];
        dl[j+1]  <= dl[j];
        dov[j+1] <= dov[j];
        dsx[j+1] <= dsx[j];
        dsy[j+1] <= dsy[j];
      end
    end
  end

  // Signed normal, rdiff and centre sums.
  logic signed [NormW-1:0] n4x, n4y;
  logic signed [RadW:0] rd4;
  logic signed [DiffW:0] sumx4, sumy4;
  logic signed [OvW-1:0] ov4;
  always_ff @(posedge clk) begin
    if (en) begin
      n4x   <= dsx[QuotW] ? -NormW'(qx[QuotW]) : NormW'(qx[QuotW]);
      n4y   <= dsy[QuotW] ? -NormW'(qy[QuotW]) : NormW'(qy[QuotW]);
      rd4   <= (RadW+1)'(dp[QuotW].radius_a) - (RadW+1)'(dp[QuotW].radius_b);
      sumx4 <= (DiffW+1)'(dp[QuotW].centre_a_x) + (DiffW+1)'(dp[QuotW].centre_b_x);
      sumy4 <= (DiffW+1)'(dp[QuotW].centre_a_y) + (DiffW+1)'(dp[QuotW].centre_b_y);
      ov4   <= dov[QuotW];
    end
  end

  // Products.
  logic signed [NormW-1:0] n5x, n5y;
  logic signed [40:0] px5, py5, sx5, sy5;
  logic signed [OvW-1:0] ov5;
  always_ff @(posedge clk) begin
    if (en) begin
      n5x <= n4x;
      n5y <= n4y;
      px5 <= 41'(n4x) * 41'(rd4);
      py5 <= 41'(n4y) * 41'(rd4);
      sx5 <= 41'(sumx4) <<< NF;
      sy5 <= 41'(sumy4) <<< NF;
      ov5 <= ov4;
    end
  end

  // Round, saturate, register the result.
  logic signed [41:0] tnx, tny;
  logic signed [26:0] vx, vy;
  contact_t res;
  always_comb begin
    tnx = 42'(sx5) + 42'(px5) + 42'(1 << NF);
    tny = 42'(sy5) + 42'(py5) + 42'(1 << NF);
    vx  = 27'(tnx >>> (NF + 1));
    vy  = 27'(tny >>> (NF + 1));
    res = '0;
    if (ov5 > 0) begin
      res.hit         = 1'b1;
      res.normal_x    = n5x;
      res.normal_y    = n5y;
      res.penetration = PenW'(ov5);
      res.contact_x   = (vx > 27'sd8388607) ? 24'sh7FFFFF :
                        (vx < -27'sd8388608) ? 24'sh800000 : 24'(vx);
      res.contact_y   = (vy > 27'sd8388607) ? 24'sh7FFFFF :
                        (vy < -27'sd8388608) ? 24'sh800000 : 24'(vy);
    end
  end

  logic out_v;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= vld[Depth-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) contact_out.data <= res;
  end
  assign contact_out.valid = out_v;

  logic unused;
  assign unused = ^{nrx[QuotW], nry[QuotW]};

  // A result with no hit carries all-zero fields.
  assert property (@(posedge clk) disable iff (rst)
    contact_out.valid && !contact_out.data.hit |->
      contact_out.data.penetration == '0 && contact_out.data.contact_x == '0)
    else $error("no-hit result carries data");
  // A stalled output holds.
  assert property (@(posedge clk) disable iff (rst)
    contact_out.valid && !contact_out.ready |=> $stable(contact_out.data))
    else $error("stalled result changed");
  // The normal's x component never exceeds one in magnitude.
  assert property (@(posedge clk) disable iff (rst)
    contact_out.valid |-> contact_out.data.normal_x <= 16'sd16384 &&
      contact_out.data.normal_x >= -16'sd16384)
    else $error("normal out of range");
endmodule
`default_nettype wire
